// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ipsc_pkg.sv =====
// Shared types, codes and constants of the idle power state controller.
package ipsc_pkg;

	localparam int LOCK_SLOTS_DEF = 8;

	localparam int IDLE_W = 24;
	localparam int TICK_W = 16;
	localparam int CFG_W  = 24;
	localparam int CIDX_W = 3;

	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	// request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_ACQUIRE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_WAKE    = 2'd3;

	// lock kinds, ordered
	localparam logic [1:0] LK_NONE    = 2'd0;
	localparam logic [1:0] LK_CPU     = 2'd1;
	localparam logic [1:0] LK_DISPLAY = 2'd2;
	localparam logic [1:0] LK_FULL    = 2'd3;

	// power states
	localparam logic [2:0] PS_ACTIVE      = 3'd0;
	localparam logic [2:0] PS_DIMMED      = 3'd1;
	localparam logic [2:0] PS_DISPLAY_OFF = 3'd2;
	localparam logic [2:0] PS_LIGHT_SLEEP = 3'd3;
	localparam logic [2:0] PS_DEEP_SLEEP  = 3'd4;

	// config register indexes
	localparam logic [CIDX_W-1:0] REG_DIM    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SCREEN = 3'd1;
	localparam logic [CIDX_W-1:0] REG_LIGHT  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_DEEP   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_TICK   = 3'd4;

	// config reset values
	localparam logic [IDLE_W-1:0] DIM_RST    = 24'd30000;
	localparam logic [IDLE_W-1:0] SCREEN_RST = 24'd45000;
	localparam logic [IDLE_W-1:0] LIGHT_RST  = 24'd60000;
	localparam logic [IDLE_W-1:0] DEEP_RST   = 24'd300000;
	localparam logic [TICK_W-1:0] TICK_RST   = 16'd1000;

	// backlight levels
	localparam logic [6:0] BL_FULL = 7'd100;
	localparam logic [6:0] BL_DIM  = 7'd20;
	localparam logic [6:0] BL_OFF  = 7'd0;

	// threshold check order of the compare unit
	localparam logic [1:0] EV_DEEP   = 2'd0;
	localparam logic [1:0] EV_LIGHT  = 2'd1;
	localparam logic [1:0] EV_SCREEN = 2'd2;
	localparam logic [1:0] EV_DIM    = 2'd3;

	typedef struct packed {
		logic [IDLE_W-1:0] dim;
		logic [IDLE_W-1:0] screen;
		logic [IDLE_W-1:0] light;
		logic [IDLE_W-1:0] deep;
	} thr_t;

	typedef struct packed {
		logic       gt;
		logic [2:0] target;
	} ev_res_t;

	function automatic logic [6:0] bl_for(input logic [2:0] ps);
		logic [6:0] bl;
		case (ps)
			PS_ACTIVE: bl = BL_FULL;
			PS_DIMMED: bl = BL_DIM;
			default:   bl = BL_OFF;
		endcase
		return bl;
	endfunction

endpackage

// ===== sv/ipsc_lock_mem.sv =====
// Lock table storage: one write port, one registered read port.
module ipsc_lock_mem #(
	parameter int SLOTS = 8,
	parameter int IW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [IW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [SLOTS];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ipsc_eval.sv =====
// Shared threshold compare unit: one idle-time compare per step.
module ipsc_eval import ipsc_pkg::*; (
	input  logic [IDLE_W-1:0] idle,
	input  thr_t              thr,
	input  logic [1:0]        step,
	output ev_res_t           res
);

	logic [IDLE_W-1:0] sel;

	always_comb begin
		case (step)
			EV_DEEP: begin
				sel        = thr.deep;
				res.target = PS_DEEP_SLEEP;
			end
			EV_LIGHT: begin
				sel        = thr.light;
				res.target = PS_LIGHT_SLEEP;
			end
			EV_SCREEN: begin
				sel        = thr.screen;
				res.target = PS_DISPLAY_OFF;
			end
			default: begin
				sel        = thr.dim;
				res.target = PS_DIMMED;
			end
		endcase
		res.gt = (idle > sel);
	end

endmodule

// ===== sv/idle_power_state_controller.sv =====
// Top level of the idle power state controller: sequencer, registers, result stage.
// Usage:
//   Input channel (in_valid/in_stall) carries one item: req_type and lock_kind.
//   Output channel (out_valid/out_stall) returns exactly one result item per input.
//   Config port: cfg_we writes cfg_data into register cfg_index (0 dim, 1 screen off,
//   2 light sleep, 3 deep sleep, 4 tick_ms); write only while the block is idle.
// Timing:
//   An item scans the lock table through one read port, one slot per cycle,
//   then ticks walk the thresholds through one shared comparator.
//   After the scan a release passes a swap step and a tick the compare steps;
//   the result is then loaded into the output register. One item is in work
//   at a time and in_stall stays high until its result is loaded into the
//   output register; the next item can be taken in the cycle after that.
// Stall: a result waits in the output register while out_stall is high; the next
//   item is accepted meanwhile and holds in its final step until the register frees.
// Reset: thresholds and tick return to defaults, state active, backlight 100,
//   no locks, idle time 0. No clearing pass is needed.
`include "assert_macros.svh"

module idle_power_state_controller import ipsc_pkg::*; #(
	parameter int LOCK_SLOTS = LOCK_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [1:0]        lock_kind,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        power_state,
	output logic [6:0]        backlight_percent,
	output logic              state_changed,
	output logic              enter_light_sleep,
	output logic              enter_deep_sleep,
	output logic [1:0]        highest_lock,
	output logic [3:0]        locks_held,
	output logic              lock_dropped,
	output logic              release_missed,
	// config port
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CW = $clog2(LOCK_SLOTS + 1);
	localparam int IW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
	localparam logic [CW-1:0] SLOTS_C = CW'(LOCK_SLOTS);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SWAP = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        st_q;
	logic [1:0]        req_q, kind_q;
	logic [CW-1:0]     cnt_q, idx_q, rd_idx_s1;
	logic              rd_v_s1;
	logic              found_q;
	logic [IW-1:0]     hit_idx_q;
	logic [1:0]        last_q, top_q;
	logic [IDLE_W-1:0] idle_q;
	logic [2:0]        ps_q;
	logic [6:0]        bl_q;
	logic              chg_q, light_q, deep_q, drop_q, miss_q;
	logic [1:0]        ev_q;
	thr_t              thr_q;
	logic [TICK_W-1:0] tick_q;

	// result register
	logic              out_valid_q;
	logic [2:0]        o_ps_q;
	logic [6:0]        o_bl_q;
	logic              o_chg_q, o_light_q, o_deep_q, o_drop_q, o_miss_q;
	logic [1:0]        o_top_q;
	logic [3:0]        o_cnt_q;

	logic              accept;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [1:0]        mem_wdata, rd_data;
	logic [IDLE_W:0]   idle_sum;
	ev_res_t           ev_res;
	logic              ev_done;
	logic [2:0]        ev_tgt;
	logic              out_free;

	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign idle_sum = {1'b0, idle_q} + (IDLE_W + 1)'(tick_q);

	// table writes: append on acquire, fill the freed slot on release
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IW-1:0];
		mem_wdata = lock_kind;
		if (accept && req_type == REQ_ACQUIRE && cnt_q < SLOTS_C) begin
			mem_we = 1'b1;
		end else if (st_q == S_SWAP && found_q) begin
			mem_we    = 1'b1;
			mem_waddr = hit_idx_q;
			mem_wdata = last_q;
		end
	end

	ipsc_lock_mem #(
		.SLOTS (LOCK_SLOTS),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	ipsc_eval u_eval (
		.idle (idle_q),
		.thr  (thr_q),
		.step (ev_q),
		.res  (ev_res)
	);

	// display/full lock pins active; cpu lock only checks screen off
	always_comb begin
		ev_done = 1'b0;
		ev_tgt  = PS_ACTIVE;
		if (top_q == LK_DISPLAY || top_q == LK_FULL) begin
			ev_done = 1'b1;
		end else if (ev_res.gt) begin
			ev_done = 1'b1;
			ev_tgt  = ev_res.target;
		end else if (ev_q == EV_DIM || top_q == LK_CPU) begin
			ev_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			req_q       <= REQ_TICK;
			kind_q      <= LK_NONE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_idx_s1   <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			hit_idx_q   <= '0;
			last_q      <= LK_NONE;
			top_q       <= LK_NONE;
			idle_q      <= '0;
			ps_q        <= PS_ACTIVE;
			bl_q        <= BL_FULL;
			chg_q       <= 1'b0;
			light_q     <= 1'b0;
			deep_q      <= 1'b0;
			drop_q      <= 1'b0;
			miss_q      <= 1'b0;
			ev_q        <= EV_DEEP;
			thr_q.dim    <= DIM_RST;
			thr_q.screen <= SCREEN_RST;
			thr_q.light  <= LIGHT_RST;
			thr_q.deep   <= DEEP_RST;
			tick_q      <= TICK_RST;
			out_valid_q <= 1'b0;
			o_ps_q      <= PS_ACTIVE;
			o_bl_q      <= BL_FULL;
			o_chg_q     <= 1'b0;
			o_light_q   <= 1'b0;
			o_deep_q    <= 1'b0;
			o_drop_q    <= 1'b0;
			o_miss_q    <= 1'b0;
			o_top_q     <= LK_NONE;
			o_cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIM:    thr_q.dim    <= cfg_data;
					REG_SCREEN: thr_q.screen <= cfg_data;
					REG_LIGHT:  thr_q.light  <= cfg_data;
					REG_DEEP:   thr_q.deep   <= cfg_data;
					REG_TICK:   tick_q       <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end

			// in S_DONE a free register is reloaded below
			if (out_valid_q && !out_stall && st_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req_type;
						kind_q  <= lock_kind;
						chg_q   <= 1'b0;
						light_q <= 1'b0;
						deep_q  <= 1'b0;
						drop_q  <= 1'b0;
						miss_q  <= 1'b0;
						found_q <= 1'b0;
						top_q   <= LK_NONE;
						idx_q   <= '0;
						rd_v_s1 <= 1'b0;
						case (req_type)
							REQ_TICK: begin
								idle_q <= idle_sum[IDLE_W] ? IDLE_MAX : idle_sum[IDLE_W-1:0];
							end
							REQ_ACQUIRE: begin
								idle_q <= '0;
								if (cnt_q < SLOTS_C) begin
									cnt_q <= cnt_q + ONE_C;
								end else begin
									drop_q <= 1'b1;
								end
							end
							REQ_WAKE: begin
								idle_q <= '0;
								if (ps_q != PS_ACTIVE) begin
									ps_q  <= PS_ACTIVE;
									bl_q  <= BL_FULL;
									chg_q <= 1'b1;
								end
							end
							default: ;
						endcase
						st_q <= S_SCAN;
					end
				end
				// one slot read per cycle; compare runs in the cycle after the read
				S_SCAN: begin
					if (idx_q < cnt_q) begin
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= idx_q;
						idx_q     <= idx_q + ONE_C;
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (rd_v_s1) begin
						if (rd_idx_s1 == cnt_q - ONE_C) begin
							last_q <= rd_data;
						end
						// first match of a release is left out of the max
						if (req_q == REQ_RELEASE && !found_q && rd_data == kind_q) begin
							found_q   <= 1'b1;
							hit_idx_q <= rd_idx_s1[IW-1:0];
						end else if (rd_data > top_q) begin
							top_q <= rd_data;
						end
					end
					if (idx_q >= cnt_q && !rd_v_s1) begin
						case (req_q)
							REQ_RELEASE: st_q <= S_SWAP;
							REQ_TICK: begin
								ev_q <= (top_q == LK_CPU) ? EV_SCREEN : EV_DEEP;
								st_q <= S_EVAL;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_SWAP: begin
					if (found_q) begin
						cnt_q <= cnt_q - ONE_C;
					end else begin
						miss_q <= 1'b1;
					end
					st_q <= S_DONE;
				end
				S_EVAL: begin
					if (ev_done) begin
						if (ev_tgt != ps_q) begin
							chg_q   <= 1'b1;
							ps_q    <= ev_tgt;
							bl_q    <= bl_for(ev_tgt);
							light_q <= (ev_tgt == PS_LIGHT_SLEEP);
							deep_q  <= (ev_tgt == PS_DEEP_SLEEP);
						end
						st_q <= S_DONE;
					end else begin
						ev_q <= ev_q + 2'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						o_ps_q      <= ps_q;
						o_bl_q      <= bl_q;
						o_chg_q     <= chg_q;
						o_light_q   <= light_q;
						o_deep_q    <= deep_q;
						o_drop_q    <= drop_q;
						o_miss_q    <= miss_q;
						o_top_q     <= top_q;
						o_cnt_q     <= 4'(cnt_q);
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign power_state       = o_ps_q;
	assign backlight_percent = o_bl_q;
	assign state_changed     = o_chg_q;
	assign enter_light_sleep = o_light_q;
	assign enter_deep_sleep  = o_deep_q;
	assign highest_lock      = o_top_q;
	assign locks_held        = o_cnt_q;
	assign lock_dropped      = o_drop_q;
	assign release_missed    = o_miss_q;

	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= SLOTS_C, "lock count above table size")
	`ASSERT_NEXT(a_busy_after_accept, accept, st_q != S_IDLE, "no work after accepted item")
	`ASSERT_IMPL(a_bl_active, ps_q == PS_ACTIVE, bl_q == BL_FULL, "active without full backlight")
	`ASSERT_IMPL(a_pulse_chg, out_valid_q && (o_light_q || o_deep_q), o_chg_q, "sleep pulse without change")

endmodule

// ===== tb/sv/power_state_checker.sv =====
// Checker for the idle power state controller: models the block, compares every result item.
`timescale 1ns / 1ps

module power_state_checker import ipsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [1:0]        lock_kind,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [2:0]        power_state,
	input  logic [6:0]        backlight_percent,
	input  logic              state_changed,
	input  logic              enter_light_sleep,
	input  logic              enter_deep_sleep,
	input  logic [1:0]        highest_lock,
	input  logic [3:0]        locks_held,
	input  logic              lock_dropped,
	input  logic              release_missed,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [2:0] state;
		logic [6:0] backlight;
		logic       changed;
		logic       light;
		logic       deep;
		logic [1:0] top;
		logic [3:0] held;
		logic       dropped;
		logic       missed;
	} power_result_t;

	// shadow registers
	logic [IDLE_W-1:0] dim_thr, screen_thr, light_thr, deep_thr;
	logic [TICK_W-1:0] tick_step;

	// shadow state
	logic [2:0]        cur_state;
	logic [6:0]        cur_backlight;
	logic [IDLE_W-1:0] idle_ms;
	logic [1:0]        locks [LOCK_SLOTS_DEF];
	int                lock_cnt;

	power_result_t expected_results [$];
	power_result_t want, got;
	int errors;

	assign fail_count = errors;

	function automatic logic [1:0] strongest_lock();
		logic [1:0] best;
		best = LK_NONE;
		for (int i = 0; i < lock_cnt; i++)
			if (locks[i] > best) best = locks[i];
		return best;
	endfunction

	function automatic logic [2:0] next_power_state(input logic [1:0] lk);
		logic [2:0] ps;
		if (lk == LK_FULL || lk == LK_DISPLAY) ps = PS_ACTIVE;
		else if (lk == LK_CPU) ps = (idle_ms > screen_thr) ? PS_DISPLAY_OFF : PS_ACTIVE;
		else if (idle_ms > deep_thr) ps = PS_DEEP_SLEEP;
		else if (idle_ms > light_thr) ps = PS_LIGHT_SLEEP;
		else if (idle_ms > screen_thr) ps = PS_DISPLAY_OFF;
		else if (idle_ms > dim_thr) ps = PS_DIMMED;
		else ps = PS_ACTIVE;
		return ps;
	endfunction

	task automatic apply_request(input logic [1:0] req, input logic [1:0] kind,
			output power_result_t r);
		logic [IDLE_W:0] sum;
		logic [2:0]      target;
		logic            found;
		r = '0;
		case (req)
			REQ_ACQUIRE: begin
				if (lock_cnt < LOCK_SLOTS_DEF) begin
					locks[lock_cnt] = kind;
					lock_cnt++;
				end else begin
					r.dropped = 1'b1;
				end
				idle_ms = '0;
			end
			REQ_RELEASE: begin
				found = 1'b0;
				// first match takes the last entry
				for (int i = 0; i < lock_cnt && !found; i++) begin
					if (locks[i] == kind) begin
						lock_cnt--;
						locks[i] = locks[lock_cnt];
						found = 1'b1;
					end
				end
				r.missed = !found;
			end
			REQ_WAKE: begin
				idle_ms = '0;
				if (cur_state != PS_ACTIVE) begin
					cur_backlight = BL_FULL;
					cur_state = PS_ACTIVE;
					r.changed = 1'b1;
				end
			end
			default: begin
				sum = {1'b0, idle_ms} + tick_step;
				idle_ms = (sum > IDLE_MAX) ? IDLE_MAX : sum[IDLE_W-1:0];
				target = next_power_state(strongest_lock());
				if (target != cur_state) begin
					r.changed = 1'b1;
					case (target)
						PS_ACTIVE: cur_backlight = BL_FULL;
						PS_DIMMED: cur_backlight = BL_DIM;
						default:   cur_backlight = BL_OFF;
					endcase
					r.light = (target == PS_LIGHT_SLEEP);
					r.deep = (target == PS_DEEP_SLEEP);
					cur_state = target;
				end
			end
		endcase
		r.state = cur_state;
		r.backlight = cur_backlight;
		r.top = strongest_lock();
		r.held = 4'(lock_cnt);
	endtask

	task automatic compare_field(input string name, input int unsigned expv,
			input int unsigned actv);
		if (expv != actv) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_thr = DIM_RST;
			screen_thr = SCREEN_RST;
			light_thr = LIGHT_RST;
			deep_thr = DEEP_RST;
			tick_step = TICK_RST;
			cur_state = PS_ACTIVE;
			cur_backlight = BL_FULL;
			idle_ms = '0;
			lock_cnt = 0;
			for (int i = 0; i < LOCK_SLOTS_DEF; i++) locks[i] = LK_NONE;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIM:    dim_thr = cfg_data;
					REG_SCREEN: screen_thr = cfg_data;
					REG_LIGHT:  light_thr = cfg_data;
					REG_DEEP:   deep_thr = cfg_data;
					REG_TICK:   tick_step = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{power_state, backlight_percent, state_changed, enter_light_sleep,
					enter_deep_sleep, highest_lock, locks_held, lock_dropped, release_missed};
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result item with nothing expected, state %0d", $time,
						power_state);
				end else begin
					want = expected_results.pop_front();
					compare_field("power_state", want.state, got.state);
					compare_field("backlight_percent", want.backlight, got.backlight);
					compare_field("state_changed", want.changed, got.changed);
					compare_field("enter_light_sleep", want.light, got.light);
					compare_field("enter_deep_sleep", want.deep, got.deep);
					compare_field("highest_lock", want.top, got.top);
					compare_field("locks_held", want.held, got.held);
					compare_field("lock_dropped", want.dropped, got.dropped);
					compare_field("release_missed", want.missed, got.missed);
				end
			end
			if (in_valid && !in_stall) begin
				apply_request(req_type, lock_kind, want);
				expected_results.push_back(want);
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/sv/idle_power_state_controller_test.sv =====
// Testbench top for the idle power state controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module idle_power_state_controller_test import ipsc_pkg::*;;

	// index with no register behind it; writes must be ignored
	localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [IDLE_W-1:0] THR_MAX = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid, in_stall;
	logic [1:0]        req_type, lock_kind;
	logic              out_valid, out_stall;
	logic [2:0]        power_state;
	logic [6:0]        backlight_percent;
	logic              state_changed, enter_light_sleep, enter_deep_sleep;
	logic [1:0]        highest_lock;
	logic [3:0]        locks_held;
	logic              lock_dropped, release_missed;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	int fail_count, pending;

	// idle odds per cycle, in percent, for each side
	int src_idle_pct = 35;
	int snk_idle_pct = 35;

	int sink_cycles = 0;
	int hold_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	idle_power_state_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .lock_kind(lock_kind),
		.out_valid(out_valid), .out_stall(out_stall),
		.power_state(power_state), .backlight_percent(backlight_percent),
		.state_changed(state_changed), .enter_light_sleep(enter_light_sleep),
		.enter_deep_sleep(enter_deep_sleep), .highest_lock(highest_lock),
		.locks_held(locks_held), .lock_dropped(lock_dropped),
		.release_missed(release_missed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	power_state_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .lock_kind(lock_kind),
		.out_valid(out_valid), .out_stall(out_stall),
		.power_state(power_state), .backlight_percent(backlight_percent),
		.state_changed(state_changed), .enter_light_sleep(enter_light_sleep),
		.enter_deep_sleep(enter_deep_sleep), .highest_lock(highest_lock),
		.locks_held(locks_held), .lock_dropped(lock_dropped),
		.release_missed(release_missed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Register write; cfg_we stays high so back-to-back writes never
	// lower and raise it in the same step. Caller drops it afterwards.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// All five registers. Upper byte of the tick write is junk to check masking.
	task automatic set_config(input logic [IDLE_W-1:0] d, input logic [IDLE_W-1:0] s,
			input logic [IDLE_W-1:0] l, input logic [IDLE_W-1:0] dp,
			input logic [TICK_W-1:0] t);
		write_reg(REG_DIM, d);
		write_reg(REG_SCREEN, s);
		write_reg(REG_LIGHT, l);
		write_reg(REG_DEEP, dp);
		write_reg(REG_TICK, {8'($urandom_range(255)), t});
		cfg_we <= 1'b0;
	endtask

	// Offer one item, with random idle cycles ahead of it. Returns at the
	// edge where it was taken; valid stays high so the next item can follow.
	task automatic send_item(input logic [1:0] r, input logic [1:0] k);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		lock_kind <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Ticks get tick_pct percent; the rest split acquire/release/wake 4:4:2.
	task automatic run_random(input int n, input int tick_pct);
		int pick;
		logic [1:0] r;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < tick_pct) begin
				r = REQ_TICK;
			end else begin
				pick = $urandom_range(9);
				r = (pick < 4) ? REQ_ACQUIRE : (pick < 8) ? REQ_RELEASE : REQ_WAKE;
			end
			send_item(r, 2'($urandom_range(3)));
		end
	endtask

	// Empty the lock table; surplus releases just miss.
	task automatic clear_locks();
		for (int k = int'(LK_FULL); k >= int'(LK_NONE); k--)
			repeat (LOCK_SLOTS_DEF) send_item(REQ_RELEASE, 2'(k));
	endtask

	// Wait until every result is back. pending is registered, so drain waits
	// for the next edge first; pending then covers the item taken just now.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_small_config(input int max_tick);
		set_config(24'($urandom_range(40)), 24'($urandom_range(40)),
			24'($urandom_range(40)), 24'($urandom_range(40)),
			16'($urandom_range(max_tick, 1)));
	endtask

	// Sink: random stall, plus two long hold-offs so the block backs up
	// and stalls its input while the source keeps offering.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			sink_cycles++;
			if (sink_cycles == 3000 || sink_cycles == 15000) hold_left = 300;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < snk_idle_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		lock_kind = LK_NONE;
		cfg_we = 1'b0;
		cfg_index = REG_DIM;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tiny thresholds, one ms per tick, so each state is a
		// tick or two away.
		set_config(24'd1, 24'd2, 24'd3, 24'd4, 16'd1);
		send_item(REQ_WAKE, LK_NONE);       // wake while already active
		send_item(REQ_TICK, LK_NONE);       // idle 1, not past dim
		send_item(REQ_TICK, LK_NONE);       // dimmed
		send_item(REQ_WAKE, LK_NONE);       // back to active
		send_item(REQ_ACQUIRE, LK_NONE);    // none is stored too
		send_item(REQ_ACQUIRE, LK_CPU);
		send_item(REQ_ACQUIRE, LK_DISPLAY);
		send_item(REQ_ACQUIRE, LK_FULL);
		send_item(REQ_ACQUIRE, LK_CPU);
		send_item(REQ_ACQUIRE, LK_DISPLAY);
		send_item(REQ_ACQUIRE, LK_NONE);
		send_item(REQ_ACQUIRE, LK_FULL);    // table full now
		send_item(REQ_ACQUIRE, LK_CPU);     // dropped
		send_item(REQ_RELEASE, LK_DISPLAY); // swap last into the hole
		send_item(REQ_RELEASE, LK_FULL);
		send_item(REQ_RELEASE, LK_DISPLAY); // match in last slot
		send_item(REQ_RELEASE, LK_FULL);
		send_item(REQ_RELEASE, LK_NONE);
		send_item(REQ_RELEASE, LK_NONE);    // two cpu locks left
		send_item(REQ_TICK, LK_NONE);
		send_item(REQ_TICK, LK_NONE);
		send_item(REQ_TICK, LK_NONE);       // cpu lock: display off
		send_item(REQ_RELEASE, LK_CPU);
		send_item(REQ_RELEASE, LK_CPU);     // table empty
		send_item(REQ_TICK, LK_NONE);       // light sleep pulse
		send_item(REQ_TICK, LK_NONE);       // deep sleep pulse
		send_item(REQ_RELEASE, LK_CPU);     // miss on empty table
		send_item(REQ_WAKE, LK_NONE);       // wake from deep sleep
		drain();

		// Reset values written back; stray write to an unused index first.
		write_reg(REG_UNUSED, 24'($urandom()));
		set_config(DIM_RST, SCREEN_RST, LIGHT_RST, DEEP_RST, TICK_RST);
		run_random(150, 75);
		drain();

		// All thresholds zero, largest tick: with no lock held, any idle time means deep sleep.
		set_config('0, '0, '0, '0, 16'hFFFF);
		run_random(100, 60);
		drain();

		// All thresholds at max: ticks alone drive idle into saturation,
		// and a saturated count never exceeds them.
		set_config(THR_MAX, THR_MAX, THR_MAX, THR_MAX, 16'hFFFF);
		run_random(260, 100);
		drain();

		// Zero tick with thresholds just below max: the saturated count
		// still trips deep sleep once the locks are gone.
		set_config(THR_MAX - 24'd1, THR_MAX - 24'd1, THR_MAX - 24'd1, THR_MAX - 24'd1,
			16'd0);
		clear_locks();
		send_item(REQ_TICK, LK_NONE);
		run_random(40, 50);
		drain();

		// No idling on either side for one stretch.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_small_config(4);
		run_random(180, 60);
		drain();
		src_idle_pct = 35;
		snk_idle_pct = 35;

		// Small random thresholds, not necessarily ordered.
		repeat (3) begin
			random_small_config(5);
			run_random(180, 60);
			drain();
		end

		// Full-range thresholds and tick, zero tick included.
		set_config(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
			16'($urandom_range(65535)));
		run_random(150, 70);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
